@@ hw/rtl/xcr_pkg.sv @@
// Shared constants, codes and types of the XMODEM checksum receiver.
`default_nettype none

package xcr_pkg;

    // Block geometry
    localparam int DATA_BYTES = 128;
    localparam int POS_W      = $clog2(DATA_BYTES + 1);

    // Line codes
    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [7:0] ACK_CODE = 8'h06;
    localparam logic [7:0] NAK_CODE = 8'h15;
    localparam logic [7:0] CAN_CODE = 8'h18;

    // Header byte classes
    localparam logic [1:0] HDR_OTHER = 2'd0;
    localparam logic [1:0] HDR_SOH   = 2'd1;
    localparam logic [1:0] HDR_EOT   = 2'd2;
    localparam logic [1:0] HDR_CAN   = 2'd3;

    // Block verdicts
    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
    localparam logic [1:0] VERDICT_DISCARD = 2'd2;

    // Transfer status
    localparam logic [1:0] FIN_RUNNING = 2'd0;
    localparam logic [1:0] FIN_OK      = 2'd1;
    localparam logic [1:0] FIN_ABORT   = 2'd2;

    // Configuration registers
    localparam int         CFG_IDX_W     = 1;
    localparam logic [0:0] REG_TIMEOUT   = 1'b0;
    localparam logic [0:0] REG_RETRY     = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [3:0]  RETRY_RESET   = 4'd10;
    localparam logic [3:0]  RETRY_MAX     = 4'd15;

    // Event queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       is_tick;
        logic [1:0] hdr_class;
        logic [7:0] rx_byte;
    } evt_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic [1:0] verdict;
        logic [1:0] finished;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/xcr_if.sv @@
// Channel interfaces of the XMODEM checksum receiver: input events, results, config writes.
`default_nettype none

interface xcr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface xcr_result_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] verdict;
    logic [1:0] finished;

    modport source (output valid, output data_valid, output data_byte, output reply_valid,
                    output reply_byte, output verdict, output finished, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input reply_valid,
                    input reply_byte, input verdict, input finished, output ready);
endinterface

interface xcr_cfg_if;
    import xcr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xcr_front.sv @@
// Front end: accepts input requests and classifies them into queue events.
`default_nettype none

module xcr_front (
    xcr_item_if.sink     item,
    input  logic         q_full,
    output logic         evt_push,
    output xcr_pkg::evt_t evt
);
    import xcr_pkg::*;

    logic [6:0] masked;

    // Accept while the queue has room
    assign item.ready = !q_full;
    assign evt_push   = item.valid && !q_full;

    // Classify the byte as a header code, ignoring bit 7
    assign masked = item.rx_byte[6:0];

    always_comb
    begin
        evt.is_tick = item.action;
        evt.rx_byte = item.rx_byte;
        if (masked == SOH_CODE[6:0])
        begin
            evt.hdr_class = HDR_SOH;
        end
        else if (masked == EOT_CODE[6:0])
        begin
            evt.hdr_class = HDR_EOT;
        end
        else if (masked == CAN_CODE[6:0])
        begin
            evt.hdr_class = HDR_CAN;
        end
        else
        begin
            evt.hdr_class = HDR_OTHER;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xcr_queue.sv @@
// Short event queue between the front end and the protocol engine.
`default_nettype none

module xcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xcr_pkg::evt_t push_evt,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output xcr_pkg::evt_t head_evt
);
    import xcr_pkg::*;

    evt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_evt   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xcr_engine.sv @@
// Back end: XMODEM receive protocol state machine with a registered result stage.
`default_nettype none

module xcr_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  xcr_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  xcr_pkg::evt_t  q_evt,
    output logic           q_pop,
    xcr_result_if.source   result
);
    import xcr_pkg::*;

    localparam logic [2:0] PH_INIT       = 3'd0;
    localparam logic [2:0] PH_HEADER     = 3'd1;
    localparam logic [2:0] PH_BLKNUM     = 3'd2;
    localparam logic [2:0] PH_COMPL      = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_SUM        = 3'd5;
    localparam logic [2:0] PH_DONE_OK    = 3'd6;
    localparam logic [2:0] PH_DONE_ABORT = 3'd7;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       exp_reg, exp_next;
    logic [3:0]       retry_reg, retry_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       blk_reg, blk_next;
    logic [7:0]       compl_reg, compl_next;
    logic [15:0]      tick_reg, tick_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic [16:0]      tick_inc;
    logic [3:0]       retry_eff;
    logic [7:0]       prev_blk;

    function automatic logic [3:0] bump(input logic [3:0] cnt);
        bump = (cnt < RETRY_MAX) ? cnt + 4'd1 : cnt;
    endfunction

    // Take the next event when the result stage is free or draining
    assign q_pop = q_valid && (!out_valid_reg || result.ready);

    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    assign retry_eff = (phase_reg == PH_INIT) ? 4'd0 : retry_reg;
    assign prev_blk  = exp_reg - 8'd1;

    // Protocol step for one event
    always_comb
    begin
        phase_next = phase_reg;
        exp_next   = exp_reg;
        retry_next = retry_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        blk_next   = blk_reg;
        compl_next = compl_reg;
        tick_next  = tick_reg;
        res_next   = '0;

        if (phase_reg != PH_DONE_OK && phase_reg != PH_DONE_ABORT)
        begin
            if (q_evt.is_tick)
            begin
                if (tick_inc >= {1'b0, cfg.timeout_ticks})
                begin
                    // Timeout: NAK, then retry or give up
                    tick_next            = '0;
                    res_next.reply_valid = 1'b1;
                    res_next.reply_byte  = NAK_CODE;
                    if (phase_reg == PH_INIT || phase_reg == PH_HEADER)
                    begin
                        if (retry_reg >= cfg.retry_limit)
                        begin
                            phase_next = PH_DONE_ABORT;
                        end
                        else
                        begin
                            retry_next = bump(retry_reg);
                        end
                    end
                    else
                    begin
                        retry_next       = bump(retry_reg);
                        res_next.verdict = VERDICT_DISCARD;
                        phase_next       = PH_HEADER;
                    end
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                end
            end
            else
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_INIT, PH_HEADER:
                    begin
                        if (phase_reg == PH_INIT)
                        begin
                            exp_next = 8'd1;
                        end
                        retry_next = retry_eff;
                        if (retry_eff >= cfg.retry_limit)
                        begin
                            res_next.reply_valid = 1'b1;
                            res_next.reply_byte  = CAN_CODE;
                            phase_next           = PH_DONE_ABORT;
                        end
                        else
                        begin
                            case (q_evt.hdr_class)
                                HDR_SOH:
                                begin
                                    retry_next = '0;
                                    pos_next   = '0;
                                    sum_next   = '0;
                                    phase_next = PH_BLKNUM;
                                end
                                HDR_CAN:
                                begin
                                    phase_next = PH_DONE_ABORT;
                                end
                                HDR_EOT:
                                begin
                                    res_next.reply_valid = 1'b1;
                                    res_next.reply_byte  = ACK_CODE;
                                    phase_next           = PH_DONE_OK;
                                end
                                default:
                                begin
                                    res_next.reply_valid = 1'b1;
                                    res_next.reply_byte  = NAK_CODE;
                                    retry_next           = bump(retry_eff);
                                end
                            endcase
                        end
                    end
                    PH_BLKNUM:
                    begin
                        blk_next   = q_evt.rx_byte;
                        phase_next = PH_COMPL;
                    end
                    PH_COMPL:
                    begin
                        compl_next = q_evt.rx_byte;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        res_next.data_valid = 1'b1;
                        res_next.data_byte  = q_evt.rx_byte;
                        sum_next            = sum_reg + q_evt.rx_byte;
                        pos_next            = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(DATA_BYTES - 1))
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        // Checksum byte decides the block
                        res_next.verdict     = VERDICT_DISCARD;
                        res_next.reply_valid = 1'b1;
                        phase_next           = PH_HEADER;
                        if (blk_reg != exp_reg)
                        begin
                            if (blk_reg != prev_blk && compl_reg != ~exp_reg)
                            begin
                                if (compl_reg == ~prev_blk)
                                begin
                                    res_next.reply_byte = NAK_CODE;
                                    retry_next          = bump(retry_reg);
                                end
                                else
                                begin
                                    // Lost sync
                                    res_next.reply_byte = CAN_CODE;
                                    phase_next          = PH_DONE_ABORT;
                                end
                            end
                            else
                            begin
                                // Duplicate block
                                res_next.reply_byte = ACK_CODE;
                                retry_next          = bump(retry_reg);
                            end
                        end
                        else if (compl_reg != ~exp_reg || q_evt.rx_byte != sum_reg)
                        begin
                            res_next.reply_byte = NAK_CODE;
                            retry_next          = bump(retry_reg);
                        end
                        else
                        begin
                            res_next.verdict    = VERDICT_COMMIT;
                            res_next.reply_byte = ACK_CODE;
                            retry_next          = '0;
                            exp_next            = exp_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (phase_next == PH_DONE_OK)
        begin
            res_next.finished = FIN_OK;
        end
        else if (phase_next == PH_DONE_ABORT)
        begin
            res_next.finished = FIN_ABORT;
        end
        else
        begin
            res_next.finished = FIN_RUNNING;
        end
    end

    // Hold a result until taken, refill on pop
    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            exp_reg       <= 8'd1;
            retry_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            blk_reg       <= '0;
            compl_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg <= phase_next;
                exp_reg   <= exp_next;
                retry_reg <= retry_next;
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                blk_reg   <= blk_next;
                compl_reg <= compl_next;
                tick_reg  <= tick_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.data_valid  = res_reg.data_valid;
    assign result.data_byte   = res_reg.data_byte;
    assign result.reply_valid = res_reg.reply_valid;
    assign result.reply_byte  = res_reg.reply_byte;
    assign result.verdict     = res_reg.verdict;
    assign result.finished    = res_reg.finished;

endmodule

`default_nettype wire

@@ hw/rtl/xmodem_checksum_receiver.sv @@
// Top level of the XMODEM checksum receiver: config registers, front end, queue, engine.
//
//   channel  role    payload                                           handshake
//   item     sink    action, rx_byte                                   valid/ready
//   result   source  data_valid, data_byte, reply_valid, reply_byte,   valid/ready
//                    verdict, finished
//   cfg      sink    index (0 timeout_ticks, 1 retry_limit), data      valid/ready
//
// One request per cycle is sustained while the result side is not stalled; each passes
// through a queue entry, then the protocol engine step into the result register.
// The engine's single-step state update sets the rate: one event per clock while the result is taken.
// The two-entry queue lets the input side accept up to two events while the result stalls.
// Reset clears all control state and loads the config defaults; cfg is always ready.
`default_nettype none

module xmodem_checksum_receiver (
    input  logic          clk,
    input  logic          rst_n,
    xcr_item_if.sink      item,
    xcr_result_if.source  result,
    xcr_cfg_if.sink       cfg
);
    import xcr_pkg::*;

    cfg_t cfg_reg;
    evt_t front_evt;
    evt_t head_evt;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    // Config writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.retry_limit   <= RETRY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TIMEOUT: cfg_reg.timeout_ticks <= cfg.data;
                REG_RETRY:   cfg_reg.retry_limit   <= cfg.data[3:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    xcr_front u_front (
        .item     (item),
        .q_full   (q_full),
        .evt_push (front_push),
        .evt      (front_evt)
    );

    xcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_evt   (front_evt),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_evt   (head_evt)
    );

    xcr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_evt   (head_evt),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/xcr_checker.sv @@
// Port-level checks of the XMODEM checksum receiver, bound to the top level.
`default_nettype none

module xcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       data_valid,
    input logic [7:0] data_byte,
    input logic       reply_valid,
    input logic [7:0] reply_byte,
    input logic [1:0] verdict,
    input logic [1:0] finished
);
    import xcr_pkg::*;

    logic [1:0] seen_reg;
    logic       res_take;

    assign res_take = res_valid && res_ready;

    // Remember the last delivered transfer status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= FIN_RUNNING;
        end
        else if (res_take)
        begin
            seen_reg <= finished;
        end
    end

    // Once ended, the transfer stays ended with the same status
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_take && seen_reg != FIN_RUNNING) |-> (finished == seen_reg))
        else $error("finished status changed after the end of the transfer");

    // A reply is one of the three codes, and a result without a reply carries zero
    a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (reply_valid ? (reply_byte == ACK_CODE || reply_byte == NAK_CODE
                                      || reply_byte == CAN_CODE)
                                   : (reply_byte == 8'h00)))
        else $error("bad reply byte");

    // A data byte never comes with a reply, a verdict or an end of transfer
    a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && data_valid) |-> (!reply_valid && verdict == VERDICT_NONE
                                       && finished == FIN_RUNNING))
        else $error("data byte mixed with a reply or verdict");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(data_byte)
                                       && $stable(reply_byte) && $stable(verdict)))
        else $error("stalled result changed");

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .data_valid  (result.data_valid),
    .data_byte   (result.data_byte),
    .reply_valid (result.reply_valid),
    .reply_byte  (result.reply_byte),
    .verdict     (result.verdict),
    .finished    (result.finished)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the XMODEM checksum receiver: directed and random event streams, self-checking.
`timescale 1ns / 100ps

module tb_top;
    import xcr_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT, ST_HEADER, ST_BLKNUM, ST_COMPL, ST_DATA, ST_SUM, ST_COMPLETE, ST_ABORTED
    } rx_phase_t;

    typedef enum int {
        BLK_GOOD, BLK_BAD_SUM, BLK_BAD_COMPL, BLK_DUP_NUM, BLK_DUP_COMPL, BLK_PREV_COMPL,
        BLK_CUT, BLK_LOST_SYNC
    } block_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    xcr_item_if   item_ch ();
    xcr_result_if result_ch ();
    xcr_cfg_if    cfg_ch ();

    xmodem_checksum_receiver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Receiver mirror: configuration and protocol state
    logic [15:0] cfg_timeout     = TIMEOUT_RESET;
    logic [3:0]  cfg_retry_limit = RETRY_RESET;
    rx_phase_t   rx_phase        = ST_INIT;
    logic [7:0]  exp_block       = 8'd1;
    logic [3:0]  retries         = 4'd0;
    int          data_count      = 0;
    logic [7:0]  block_sum       = 8'd0;
    logic [7:0]  blk_num         = 8'd0;
    logic [7:0]  blk_compl       = 8'd0;
    logic [15:0] ticks           = 16'd0;
    result_t     outcome;

    result_t outcomes_due[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      gap_pct    = 0;
    int      stall_pct  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void raise_retries();
        if (retries < RETRY_MAX)
            retries = retries + 4'd1;
    endfunction

    function automatic void answer(input logic [7:0] code);
        outcome.reply_valid = 1'b1;
        outcome.reply_byte  = code;
    endfunction

    function automatic void take_header(input logic [7:0] b);
        if (retries >= cfg_retry_limit)
        begin
            answer(CAN_CODE);
            rx_phase = ST_ABORTED;
        end
        else
        begin
            case ({1'b0, b[6:0]})
                SOH_CODE:
                begin
                    retries    = 4'd0;
                    data_count = 0;
                    block_sum  = 8'd0;
                    rx_phase   = ST_BLKNUM;
                end
                CAN_CODE: rx_phase = ST_ABORTED;
                EOT_CODE:
                begin
                    answer(ACK_CODE);
                    rx_phase = ST_COMPLETE;
                end
                default:
                begin
                    answer(NAK_CODE);
                    raise_retries();
                end
            endcase
        end
    endfunction

    // Judge a finished block from its number, complement and checksum byte
    function automatic void close_block(input logic [7:0] b);
        logic [7:0] prev_blk;
        logic [7:0] not_exp;
        logic [7:0] not_prev;
        prev_blk = exp_block - 8'd1;
        not_exp  = 8'hff - exp_block;
        not_prev = 8'hff - prev_blk;
        outcome.verdict = VERDICT_DISCARD;
        rx_phase = ST_HEADER;
        if (blk_num != exp_block)
        begin
            if (blk_num != prev_blk && blk_compl != not_exp)
            begin
                if (blk_compl == not_prev)
                begin
                    answer(NAK_CODE);
                    raise_retries();
                end
                else
                begin
                    answer(CAN_CODE);
                    rx_phase = ST_ABORTED;
                end
            end
            else
            begin
                raise_retries();
                answer(ACK_CODE);
            end
        end
        else if (blk_compl != not_exp || b != block_sum)
        begin
            answer(NAK_CODE);
            raise_retries();
        end
        else
        begin
            outcome.verdict = VERDICT_COMMIT;
            retries   = 4'd0;
            exp_block = exp_block + 8'd1;
            answer(ACK_CODE);
        end
    endfunction

    function automatic void time_out();
        answer(NAK_CODE);
        if (rx_phase == ST_INIT || rx_phase == ST_HEADER)
        begin
            if (retries >= cfg_retry_limit)
                rx_phase = ST_ABORTED;
            else
                raise_retries();
        end
        else
        begin
            raise_retries();
            outcome.verdict = VERDICT_DISCARD;
            rx_phase = ST_HEADER;
        end
    endfunction

    // Advance the mirror by one event and return the result it must produce
    function automatic result_t xmodem_outcome(input logic act, input logic [7:0] b);
        outcome = '0;
        if (rx_phase != ST_COMPLETE && rx_phase != ST_ABORTED)
        begin
            if (act)
            begin
                if (int'(ticks) + 1 >= int'(cfg_timeout))
                begin
                    ticks = 16'd0;
                    time_out();
                end
                else
                    ticks = ticks + 16'd1;
            end
            else
            begin
                ticks = 16'd0;
                case (rx_phase)
                    ST_INIT:
                    begin
                        exp_block = 8'd1;
                        retries   = 4'd0;
                        take_header(b);
                    end
                    ST_HEADER: take_header(b);
                    ST_BLKNUM:
                    begin
                        blk_num  = b;
                        rx_phase = ST_COMPL;
                    end
                    ST_COMPL:
                    begin
                        blk_compl = b;
                        rx_phase  = ST_DATA;
                    end
                    ST_DATA:
                    begin
                        outcome.data_valid = 1'b1;
                        outcome.data_byte  = b;
                        block_sum  = block_sum + b;
                        data_count = data_count + 1;
                        if (data_count >= DATA_BYTES)
                            rx_phase = ST_SUM;
                    end
                    default: close_block(b);
                endcase
            end
        end
        outcome.finished = (rx_phase == ST_COMPLETE) ? FIN_OK :
                           (rx_phase == ST_ABORTED)  ? FIN_ABORT : FIN_RUNNING;
        return outcome;
    endfunction

    function automatic bit can_retry();
        return int'(retries) + 1 < int'(cfg_retry_limit);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest outstanding request
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                check_field("data_valid", 8'(want.data_valid), 8'(result_ch.data_valid));
                check_field("data_byte", want.data_byte, result_ch.data_byte);
                check_field("reply_valid", 8'(want.reply_valid), 8'(result_ch.reply_valid));
                check_field("reply_byte", want.reply_byte, result_ch.reply_byte);
                check_field("verdict", 8'(want.verdict), 8'(result_ch.verdict));
                check_field("finished", 8'(want.finished), 8'(result_ch.finished));
            end
        end
    end

    // Stall the result side at random
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // ---------------------------------------------------------------- driving

    // Send one request; called at a falling edge, returns at a falling edge
    task automatic send_event(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= act;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        outcomes_due.push_back(xmodem_outcome(act, b));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_event(1'b1, 8'($urandom));
    endtask

    // Tick now and then without reaching the timeout
    task automatic stray_tick(input int pct);
        if ($urandom_range(99) < pct && int'(ticks) + 1 < int'(cfg_timeout))
            send_tick();
    endtask

    // Header byte that is neither SOH, EOT nor CAN after masking
    task automatic send_noise();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b[6:0] == SOH_CODE[6:0] || b[6:0] == EOT_CODE[6:0] || b[6:0] == CAN_CODE[6:0]);
        send_event(1'b0, b);
    endtask

    // Hold the sender until every outstanding request has its result
    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outcomes_due.size() != 0);
    endtask

    task automatic configure(input logic [15:0] timeout_val, input logic [3:0] limit_val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_TIMEOUT;
        cfg_ch.data  <= timeout_val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_timeout = timeout_val;
        @(negedge clk);
        cfg_ch.index <= REG_RETRY;
        cfg_ch.data  <= {12'd0, limit_val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_retry_limit = limit_val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Send one block of the given kind, header byte through checksum
    task automatic send_block(input block_kind_t kind);
        logic [7:0] prev_blk;
        logic [7:0] num;
        logic [7:0] compl;
        logic [7:0] checksum;
        logic [7:0] b;
        int         stop_at;
        prev_blk = exp_block - 8'd1;
        num      = exp_block;
        compl    = 8'hff - exp_block;
        checksum = 8'd0;
        stop_at  = (kind == BLK_CUT) ? $urandom_range(DATA_BYTES + 2) : DATA_BYTES + 2;
        case (kind)
            BLK_BAD_COMPL: compl = compl ^ 8'($urandom_range(255, 1));
            BLK_DUP_NUM:
            begin
                num   = prev_blk;
                compl = 8'($urandom);
            end
            BLK_DUP_COMPL, BLK_PREV_COMPL, BLK_LOST_SYNC:
            begin
                do
                    num = 8'($urandom);
                while (num == exp_block || num == prev_blk);
                if (kind == BLK_DUP_COMPL)
                    compl = 8'hff - exp_block;
                else if (kind == BLK_PREV_COMPL)
                    compl = 8'hff - prev_blk;
                else
                    do
                        compl = 8'($urandom);
                    while (compl == 8'hff - exp_block || compl == 8'hff - prev_blk);
            end
            default: ;
        endcase
        send_event(1'b0, $urandom_range(1) ? SOH_CODE : (SOH_CODE | 8'h80));
        for (int i = 0; i < stop_at; i++)
        begin
            if (i == 0)
                b = num;
            else if (i == 1)
                b = compl;
            else
            begin
                case ($urandom_range(15))
                    0: b = 8'h00;
                    1: b = 8'hff;
                    default: b = 8'($urandom);
                endcase
                checksum = checksum + b;
            end
            stray_tick(3);
            send_event(1'b0, b);
        end
        if (kind == BLK_CUT)
        begin
            // let the block time out
            while (rx_phase != ST_HEADER)
                send_tick();
        end
        else if (kind == BLK_BAD_SUM)
            send_event(1'b0, checksum ^ 8'($urandom_range(255, 1)));
        else
            send_event(1'b0, checksum);
    endtask

    // Random mix of whole blocks, faults and header-wait events
    task automatic run_traffic(input int min_items);
        int          start;
        int          pick;
        block_kind_t kind;
        start = items_sent;
        while (items_sent - start < min_items)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_block(BLK_GOOD);
            else if (pick < 75)
            begin
                kind = block_kind_t'($urandom_range(int'(BLK_CUT), int'(BLK_BAD_SUM)));
                if (!can_retry() || (kind == BLK_CUT && cfg_timeout > 16'd64))
                    kind = BLK_GOOD;
                send_block(kind);
            end
            else if (pick < 85)
            begin
                if (can_retry())
                    send_noise();
            end
            else if (pick < 90)
            begin
                // time out while waiting for a header
                if (can_retry() && cfg_timeout <= 16'd64)
                    do
                        send_tick();
                    while (!outcome.reply_valid);
            end
            else if (pick < 96)
                repeat ($urandom_range(4, 1))
                    stray_tick(100);
            else
                drain();
        end
        // clear the retry count before the next configuration
        if (retries != 4'd0)
            send_block(BLK_GOOD);
    endtask

    // ---------------------------------------------------------------- tests

    // Initial wait, masked SOH, block timeout and header NAKs
    task automatic test_initial_wait();
        gap_pct   = 0;
        stall_pct = 0;
        configure(16'd3, 4'd15);
        repeat (3)
            send_tick();
        send_event(1'b0, 8'hff);
        send_event(1'b0, 8'h00);
        send_event(1'b1, 8'hff);
        send_event(1'b0, 8'h81);
        send_event(1'b0, 8'h01);
        send_event(1'b0, 8'hfe);
        send_event(1'b0, 8'hff);
        send_event(1'b0, 8'h00);
        repeat (3)
            send_tick();
        send_event(1'b0, 8'h80);
        send_event(1'b0, 8'h7f);
        send_event(1'b1, 8'h00);
    endtask

    task automatic test_blocks_steady();
        configure(16'd1, 4'd15);
        gap_pct   = 0;
        stall_pct = 0;
        run_traffic(100);
    endtask

    task automatic test_blocks_sender_gaps();
        configure(16'd65535, 4'd1);
        gap_pct   = 67;
        stall_pct = 0;
        run_traffic(100);
    endtask

    task automatic test_blocks_result_stalls();
        configure(16'($urandom_range(12, 2)), 4'($urandom_range(14, 2)));
        gap_pct   = 0;
        stall_pct = 67;
        run_traffic(100);
    endtask

    task automatic test_blocks_mixed_gaps();
        configure(16'($urandom_range(64, 13)), 4'($urandom_range(15, 3)));
        gap_pct   = 29;
        stall_pct = 29;
        run_traffic(100);
    endtask

    // End the transfer one way or another, then check that events are ignored
    task automatic test_transfer_end();
        configure(16'($urandom_range(4, 1)), 4'($urandom_range(4, 1)));
        gap_pct   = 29;
        stall_pct = 29;
        case ($urandom_range(4))
            0: send_event(1'b0, $urandom_range(1) ? EOT_CODE : (EOT_CODE | 8'h80));
            1: send_event(1'b0, $urandom_range(1) ? CAN_CODE : (CAN_CODE | 8'h80));
            2: send_block(BLK_LOST_SYNC);
            3:
                while (rx_phase != ST_ABORTED)
                    send_noise();
            default:
                while (rx_phase != ST_ABORTED)
                    send_tick();
        endcase
        repeat (6)
            send_event(1'($urandom_range(1)), 8'($urandom));
    endtask

    initial
    begin
        item_ch.valid    = 1'b0;
        item_ch.action   = 1'b0;
        item_ch.rx_byte  = 8'd0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_TIMEOUT;
        cfg_ch.data      = 16'd0;
        result_ch.ready  = 1'b0;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_initial_wait();
        test_blocks_steady();
        test_blocks_sender_gaps();
        test_blocks_result_stalls();
        test_blocks_mixed_gaps();
        test_transfer_end();

        // drain the pipeline and report
        item_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("xmodem_checksum_receiver regression: pass");
        else
            $display("xmodem_checksum_receiver regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("xmodem_checksum_receiver regression: fail");
        $finish;
    end

endmodule
